// ----- rtl/bspe_pkg.sv -----
// Shared types, codes and reset values of the bounded simple path enumerator.
package bspe_pkg;

    localparam int MAX_VERTICES_DEF   = 16;
    localparam int MAX_PATH_EDGES_DEF = 8;

    // Request codes.
    localparam logic [1:0] OP_SET_EDGE = 2'd0;
    localparam logic [1:0] OP_CLR_EDGE = 2'd1;
    localparam logic [1:0] OP_RESTART  = 2'd2;
    localparam logic [1:0] OP_NEXT     = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] REG_VERTEX_COUNT = 2'd0;
    localparam logic [1:0] REG_START_VERTEX = 2'd1;
    localparam logic [1:0] REG_MIN_LENGTH   = 2'd2;
    localparam logic [1:0] REG_MAX_LENGTH   = 2'd3;

    localparam logic [4:0] VERTEX_COUNT_RST = 5'd16;
    localparam logic [3:0] START_VERTEX_RST = 4'd0;
    localparam logic [3:0] MIN_LENGTH_RST   = 4'd0;
    localparam logic [3:0] MAX_LENGTH_RST   = 4'd8;

    typedef struct packed {
        logic [1:0] opcode;
        logic [3:0] from_vertex;
        logic [3:0] to_vertex;
    } cmd_item_t;

    typedef struct packed {
        logic [3:0] vertex;
        logic [3:0] position;
        logic       found;
        logic       last;
    } res_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch_in;
        logic adj_from;
        logic edge_wr;
        logic restart;
        logic init;
        logic scan;
        logic pop;
        logic path_pop;
        logic pop_ld;
        logic k_clr;
        logic k_inc;
        logic emit_ld;
        logic exh_ld;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] opcode;
        logic       edge_ok;
        logic       start_ok;
        logic       in_window;
        logic       depth_lt_max;
        logic       cursor_end;
        logic       hit;
        logic       depth_zero;
        logic       k_last;
    } dp_status_t;

endpackage

// ----- rtl/bspe_datapath.sv -----
// Datapath: configuration, adjacency memory, path stack, walk registers and result register.
module bspe_datapath #(
    parameter int MAX_VERTICES   = bspe_pkg::MAX_VERTICES_DEF,
    parameter int MAX_PATH_EDGES = bspe_pkg::MAX_PATH_EDGES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [4:0]            cfg_data,
    input  bspe_pkg::cmd_item_t   cmd,
    input  bspe_pkg::dp_cmd_t     dc,
    output bspe_pkg::dp_status_t  ds,
    output bspe_pkg::res_item_t   res
);
    import bspe_pkg::*;

    localparam int VW     = $clog2(MAX_VERTICES);
    localparam int CW     = $clog2(MAX_VERTICES + 1);
    localparam int DW     = $clog2(MAX_PATH_EDGES + 1);
    localparam int PDEPTH = MAX_PATH_EDGES + 1;

    logic [4:0] vcount_reg;
    logic [3:0] start_reg;
    logic [3:0] minlen_reg;
    logic [3:0] maxlen_reg;

    logic [3:0] from_reg;
    logic [3:0] to_reg;
    logic       clr_reg;

    logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] row_valid_reg;
    logic [MAX_VERTICES-1:0] adj_rd_reg;
    logic                    adj_rd_valid_reg;
    logic [VW-1:0]           adj_addr;
    logic [MAX_VERTICES-1:0] row;
    logic [MAX_VERTICES-1:0] to_mask;
    logic [MAX_VERTICES-1:0] row_new;

    logic [VW-1:0] path_mem [PDEPTH];
    logic [CW-1:0] cur_mem [PDEPTH];
    logic [DW-1:0] path_addr;
    logic [VW-1:0] path_rd_reg;
    logic [CW-1:0] cur_rd_reg;

    logic [DW-1:0]           depth_reg, depth_next;
    logic [MAX_VERTICES-1:0] visited_reg, visited_next;
    logic [DW-1:0]           k_reg, k_next;
    logic [VW-1:0]           cur_u_reg, cur_u_next;
    logic [CW-1:0]           cursor_reg, cursor_next;

    logic [CW-1:0]           nv;
    logic [DW-1:0]           effmax;
    logic [VW-1:0]           cur_idx;
    logic [MAX_VERTICES-1:0] cur_mask;
    logic [MAX_VERTICES-1:0] u_mask;
    logic [MAX_VERTICES-1:0] start_mask;
    logic                    push;
    logic                    step;
    logic                    cursor_end;
    logic                    hit;
    logic                    k_last;
    res_item_t               res_reg;
    res_item_t               emit_word;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vcount_reg <= VERTEX_COUNT_RST;
            start_reg  <= START_VERTEX_RST;
            minlen_reg <= MIN_LENGTH_RST;
            maxlen_reg <= MAX_LENGTH_RST;
        end
        else if (cfg_we) begin
            unique case (cfg_index)
                REG_VERTEX_COUNT: vcount_reg <= cfg_data;
                REG_START_VERTEX: start_reg  <= cfg_data[3:0];
                REG_MIN_LENGTH:   minlen_reg <= cfg_data[3:0];
                REG_MAX_LENGTH:   maxlen_reg <= cfg_data[3:0];
            endcase
        end
    end

    always_comb begin
        if (int'(vcount_reg) > MAX_VERTICES) begin
            nv = CW'(MAX_VERTICES);
        end
        else begin
            nv = CW'(vcount_reg);
        end
        if (int'(maxlen_reg) > MAX_PATH_EDGES) begin
            effmax = DW'(MAX_PATH_EDGES);
        end
        else begin
            effmax = DW'(maxlen_reg);
        end
    end

    always_ff @(posedge clk) begin
        if (dc.latch_in) begin
            from_reg <= cmd.from_vertex;
            to_reg   <= cmd.to_vertex;
            clr_reg  <= (cmd.opcode == OP_CLR_EDGE);
        end
    end

    // Rows never written read as empty through their valid bit.
    assign adj_addr = dc.adj_from ? VW'(from_reg) : cur_u_reg;
    assign row      = adj_rd_valid_reg ? adj_rd_reg : '0;

    always_comb begin
        to_mask              = '0;
        to_mask[VW'(to_reg)] = 1'b1;
        row_new              = clr_reg ? (row & ~to_mask) : (row | to_mask);
    end

    always_ff @(posedge clk) begin
        adj_rd_reg       <= adj_mem[adj_addr];
        adj_rd_valid_reg <= row_valid_reg[adj_addr];
        if (dc.edge_wr) begin
            adj_mem[VW'(from_reg)] <= row_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            row_valid_reg <= '0;
        end
        else if (dc.edge_wr) begin
            row_valid_reg[VW'(from_reg)] <= 1'b1;
        end
    end

    // Path stack: entry d holds the vertex at depth d of the path and its resume cursor.
    assign path_addr = dc.path_pop ? (depth_reg - DW'(1)) : k_reg;

    always_ff @(posedge clk) begin
        path_rd_reg <= path_mem[path_addr];
        cur_rd_reg  <= cur_mem[path_addr];
        if (push) begin
            path_mem[depth_reg] <= cur_u_reg;
            cur_mem[depth_reg]  <= cursor_reg + CW'(1);
        end
    end

    assign cur_idx    = cursor_reg[VW-1:0];
    assign cursor_end = (cursor_reg >= nv);
    assign hit        = !cursor_end && row[cur_idx] && !visited_reg[cur_idx];
    assign push       = dc.scan && hit;
    assign step       = dc.scan && !hit && !cursor_end;
    assign k_last     = (k_reg == depth_reg);

    always_comb begin
        cur_mask                   = '0;
        cur_mask[cur_idx]          = 1'b1;
        u_mask                     = '0;
        u_mask[cur_u_reg]          = 1'b1;
        start_mask                 = '0;
        start_mask[VW'(start_reg)] = 1'b1;
    end

    always_comb begin
        depth_next   = depth_reg;
        visited_next = visited_reg;
        cur_u_next   = cur_u_reg;
        cursor_next  = cursor_reg;
        k_next       = k_reg;
        if (dc.restart) begin
            depth_next   = '0;
            visited_next = '0;
        end
        else if (dc.init) begin
            depth_next   = '0;
            cur_u_next   = VW'(start_reg);
            cursor_next  = '0;
            visited_next = start_mask;
        end
        else if (push) begin
            depth_next   = depth_reg + DW'(1);
            cur_u_next   = cur_idx;
            cursor_next  = '0;
            visited_next = visited_reg | cur_mask;
        end
        else if (step) begin
            cursor_next = cursor_reg + CW'(1);
        end
        else if (dc.pop) begin
            visited_next = visited_reg & ~u_mask;
            depth_next   = depth_reg - DW'(1);
        end
        else if (dc.pop_ld) begin
            cur_u_next  = path_rd_reg;
            cursor_next = cur_rd_reg;
        end
        if (dc.k_clr) begin
            k_next = '0;
        end
        else if (dc.k_inc) begin
            k_next = k_reg + DW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            depth_reg   <= '0;
            visited_reg <= '0;
            k_reg       <= '0;
        end
        else begin
            depth_reg   <= depth_next;
            visited_reg <= visited_next;
            k_reg       <= k_next;
        end
    end

    always_ff @(posedge clk) begin
        cur_u_reg  <= cur_u_next;
        cursor_reg <= cursor_next;
    end

    // The top of the path lives in cur_u_reg, the rest comes from the stack.
    assign emit_word = '{vertex:   4'(k_last ? cur_u_reg : path_rd_reg),
                         position: 4'(k_reg),
                         found:    1'b1,
                         last:     k_last};

    always_ff @(posedge clk) begin
        if (dc.emit_ld) begin
            res_reg <= emit_word;
        end
        else if (dc.exh_ld) begin
            res_reg <= '{vertex: 4'd0, position: 4'd0, found: 1'b0, last: 1'b1};
        end
    end

    assign res = res_reg;

    always_comb begin
        ds.opcode       = cmd.opcode;
        ds.edge_ok      = (int'(cmd.from_vertex) < MAX_VERTICES)
                          && (int'(cmd.to_vertex) < MAX_VERTICES);
        ds.start_ok     = (int'(start_reg) < int'(nv)) && (int'(minlen_reg) <= int'(effmax));
        ds.in_window    = (int'(depth_reg) >= int'(minlen_reg)) && (depth_reg <= effmax);
        ds.depth_lt_max = (depth_reg < effmax);
        ds.cursor_end   = cursor_end;
        ds.hit          = hit;
        ds.depth_zero   = (depth_reg == '0);
        ds.k_last       = k_last;
    end

endmodule

// ----- rtl/bspe_ctrl.sv -----
// Controller: sequences edge edits, the depth-first walk and the emission of result words.
module bspe_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_stall,
    output logic                 res_valid,
    input  logic                 res_stall,
    input  bspe_pkg::dp_status_t ds,
    output bspe_pkg::dp_cmd_t    dc
);
    import bspe_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE    = 11'b000_0000_0001,
        S_EDGE_RD = 11'b000_0000_0010,
        S_EDGE_WR = 11'b000_0000_0100,
        S_CHECK   = 11'b000_0000_1000,
        S_ROW     = 11'b000_0001_0000,
        S_SCAN    = 11'b000_0010_0000,
        S_POP     = 11'b000_0100_0000,
        S_POP_LD  = 11'b000_1000_0000,
        S_EMIT_RD = 11'b001_0000_0000,
        S_EMIT_LD = 11'b010_0000_0000,
        S_EXH     = 11'b100_0000_0000
    } state_t;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_WALK = 3'b010,
        PH_DONE = 3'b100
    } phase_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    logic   res_valid_reg, res_valid_next;
    logic   accept;
    logic   out_free;
    logic   res_load;

    assign cmd_stall = (state_reg != S_IDLE);
    assign accept    = cmd_valid && !cmd_stall;
    assign out_free  = !res_valid_reg || !res_stall;
    assign res_valid = res_valid_reg;

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        dc         = '0;
        res_load   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    dc.latch_in = 1'b1;
                    unique case (ds.opcode)
                        OP_SET_EDGE, OP_CLR_EDGE: begin
                            if (ds.edge_ok) begin
                                state_next = S_EDGE_RD;
                            end
                        end
                        OP_RESTART: begin
                            dc.restart = 1'b1;
                            phase_next = PH_IDLE;
                        end
                        OP_NEXT: begin
                            unique case (phase_reg)
                                PH_IDLE: begin
                                    if (ds.start_ok) begin
                                        dc.init    = 1'b1;
                                        phase_next = PH_WALK;
                                        state_next = S_CHECK;
                                    end
                                    else begin
                                        phase_next = PH_DONE;
                                        state_next = S_EXH;
                                    end
                                end
                                PH_WALK: state_next = S_ROW;
                                PH_DONE: state_next = S_EXH;
                                default: state_next = S_EXH;
                            endcase
                        end
                    endcase
                end
            end
            S_EDGE_RD: begin
                dc.adj_from = 1'b1;
                state_next  = S_EDGE_WR;
            end
            S_EDGE_WR: begin
                dc.adj_from = 1'b1;
                dc.edge_wr  = 1'b1;
                state_next  = S_IDLE;
            end
            S_CHECK: begin
                if (ds.in_window) begin
                    dc.k_clr   = 1'b1;
                    state_next = S_EMIT_RD;
                end
                else begin
                    state_next = S_ROW;
                end
            end
            S_ROW: begin
                // The row of the top vertex is fetched here and seen in the scan.
                state_next = ds.depth_lt_max ? S_SCAN : S_POP;
            end
            S_SCAN: begin
                dc.scan = 1'b1;
                if (ds.cursor_end) begin
                    state_next = S_POP;
                end
                else if (ds.hit) begin
                    state_next = S_CHECK;
                end
            end
            S_POP: begin
                if (ds.depth_zero) begin
                    phase_next = PH_DONE;
                    state_next = S_EXH;
                end
                else begin
                    dc.pop      = 1'b1;
                    dc.path_pop = 1'b1;
                    state_next  = S_POP_LD;
                end
            end
            S_POP_LD: begin
                dc.pop_ld  = 1'b1;
                state_next = S_ROW;
            end
            S_EMIT_RD: begin
                state_next = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                if (out_free) begin
                    dc.emit_ld = 1'b1;
                    res_load   = 1'b1;
                    if (ds.k_last) begin
                        state_next = S_IDLE;
                    end
                    else begin
                        dc.k_inc   = 1'b1;
                        state_next = S_EMIT_RD;
                    end
                end
            end
            S_EXH: begin
                if (out_free) begin
                    dc.exh_ld  = 1'b1;
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        if (res_load) begin
            res_valid_next = 1'b1;
        end
        else if (res_valid_reg && !res_stall) begin
            res_valid_next = 1'b0;
        end
        else begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_IDLE;
            res_valid_reg <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            res_valid_reg <= res_valid_next;
        end
    end

endmodule

// ----- rtl/bounded_simple_path_enumerator_unit.sv -----
// Top level of the bounded simple path enumerator: controller, datapath and checks.
//
//   channel  direction  handshake               word
//   cmd      in         cmd_valid / cmd_stall   opcode, from_vertex, to_vertex
//   res      out        res_valid / res_stall   vertex, position, found, last
//   cfg      in         cfg_we                  cfg_index, cfg_data
//
// A restart or an ignored edge stays in idle; an edge edit reads the row, then writes it back.
// A next-path request runs the walk: the neighbor scan tests one adjacency bit per cycle, each
// arrival takes a window check and a row fetch, each backtrack a pop, a stack read and a row
// fetch, and the path words are then emitted in turn.
// Reset clears the adjacency valid bits, the walk and the result valid flag at once.
// A stalled result word holds; the next word waits in the controller until the slot frees.
module bounded_simple_path_enumerator_unit #(
    parameter int MAX_VERTICES   = bspe_pkg::MAX_VERTICES_DEF,
    parameter int MAX_PATH_EDGES = bspe_pkg::MAX_PATH_EDGES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [4:0]          cfg_data,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  bspe_pkg::cmd_item_t cmd,
    output logic                res_valid,
    input  logic                res_stall,
    output bspe_pkg::res_item_t res
);
    import bspe_pkg::*;

    dp_cmd_t    dc;
    dp_status_t ds;

    bspe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .ds        (ds),
        .dc        (dc)
    );

    bspe_datapath #(
        .MAX_VERTICES   (MAX_VERTICES),
        .MAX_PATH_EDGES (MAX_PATH_EDGES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .dc        (dc),
        .ds        (ds),
        .res       (res)
    );

    // An exhausted answer is always a single word.
    a_exhausted_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.found |-> res.last)
        else $error("exhausted word without last mark");

    // A path word never sits deeper than the depth limit.
    a_position_bound: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.found |-> int'(res.position) <= MAX_PATH_EDGES)
        else $error("path position beyond depth limit");

    // An accepted next-path request always takes the controller out of idle, so further commands stall.
    a_next_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall && cmd.opcode == OP_NEXT |=> cmd_stall)
        else $error("next-path request accepted without walking");

    // A loaded result word is presented in the following cycle.
    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (dc.emit_ld || dc.exh_ld) |=> res_valid)
        else $error("result word loaded but not presented");

endmodule

// ----- bench/tb_top.sv -----
// Self-checking testbench for the bounded simple path enumerator with a built-in path predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bspe_pkg::*;

    localparam int NV            = MAX_VERTICES_DEF;
    localparam int NE            = MAX_PATH_EDGES_DEF;
    localparam int N_PHASES      = 8;
    localparam int PHASE_ITEMS   = 36;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 20;
    localparam int QUIET_LIMIT   = 100000;
    localparam int MAX_REPORTS   = 10;

    localparam res_item_t EXHAUSTED_WORD = {4'd0, 4'd0, 1'b0, 1'b1};
    localparam res_item_t NO_WORD        = '0;

    typedef enum logic [1:0] {WALK_IDLE, WALK_ON, WALK_DONE} walk_state_t;
    typedef enum logic {ROW_CMD, ROW_REG} row_kind_t;

    // A register row writes data to register idx; a command row sends word and, where
    // typed is set, expects the single result word want.
    typedef struct packed {
        row_kind_t  kind;
        logic [1:0] idx;
        logic [4:0] data;
        cmd_item_t  word;
        logic       typed;
        res_item_t  want;
    } dir_row_t;

    localparam int N_DIR = 30;

    dir_row_t dir_rows [N_DIR] = '{
        '{ROW_CMD, '0, '0, {OP_NEXT, 4'd0, 4'd0}, 1'b1, {4'd0, 4'd0, 1'b1, 1'b1}},
        '{ROW_CMD, '0, '0, {OP_NEXT, 4'd0, 4'd0}, 1'b1, EXHAUSTED_WORD},
        '{ROW_CMD, '0, '0, {OP_NEXT, 4'd0, 4'd0}, 1'b1, EXHAUSTED_WORD},
        '{ROW_CMD, '0, '0, {OP_SET_EDGE, 4'd0, 4'd15}, 1'b0, NO_WORD},
        '{ROW_CMD, '0, '0, {OP_SET_EDGE, 4'd15, 4'd0}, 1'b0, NO_WORD},
        '{ROW_CMD, '0, '0, {OP_SET_EDGE, 4'd0, 4'd1}, 1'b0, NO_WORD},
        '{ROW_CMD, '0, '0, {OP_SET_EDGE, 4'd1, 4'd2}, 1'b0, NO_WORD},
        '{ROW_CMD, '0, '0, {OP_SET_EDGE, 4'd2, 4'd0}, 1'b0, NO_WORD},
        '{ROW_CMD, '0, '0, {OP_RESTART, 4'd0, 4'd0}, 1'b0, NO_WORD},
        '{ROW_CMD, '0, '0, {OP_NEXT, 4'd0, 4'd0}, 1'b0, NO_WORD},
        '{ROW_CMD, '0, '0, {OP_NEXT, 4'd0, 4'd0}, 1'b0, NO_WORD},
        // Removing an edge in the middle of a walk; later scans must see the change.
        '{ROW_CMD, '0, '0, {OP_CLR_EDGE, 4'd1, 4'd2}, 1'b0, NO_WORD},
        '{ROW_CMD, '0, '0, {OP_NEXT, 4'd0, 4'd0}, 1'b0, NO_WORD},
        '{ROW_CMD, '0, '0, {OP_NEXT, 4'd0, 4'd0}, 1'b1, EXHAUSTED_WORD},
        // Length window that is empty once the maximum is capped.
        '{ROW_REG, REG_MIN_LENGTH, 5'd9, '0, 1'b0, NO_WORD},
        '{ROW_REG, REG_MAX_LENGTH, 5'd15, '0, 1'b0, NO_WORD},
        '{ROW_CMD, '0, '0, {OP_RESTART, 4'd0, 4'd0}, 1'b0, NO_WORD},
        '{ROW_CMD, '0, '0, {OP_NEXT, 4'd0, 4'd0}, 1'b1, EXHAUSTED_WORD},
        // No vertices in use, so the start vertex is out of range.
        '{ROW_REG, REG_VERTEX_COUNT, 5'd0, '0, 1'b0, NO_WORD},
        '{ROW_REG, REG_MIN_LENGTH, 5'd0, '0, 1'b0, NO_WORD},
        '{ROW_REG, REG_MAX_LENGTH, 5'd0, '0, 1'b0, NO_WORD},
        '{ROW_CMD, '0, '0, {OP_RESTART, 4'd0, 4'd0}, 1'b0, NO_WORD},
        '{ROW_CMD, '0, '0, {OP_NEXT, 4'd0, 4'd0}, 1'b1, EXHAUSTED_WORD},
        // Oversized vertex count and the top start vertex, with a zero-edge limit.
        '{ROW_REG, REG_VERTEX_COUNT, 5'd31, '0, 1'b0, NO_WORD},
        '{ROW_REG, REG_START_VERTEX, 5'd31, '0, 1'b0, NO_WORD},
        '{ROW_CMD, '0, '0, {OP_RESTART, 4'd0, 4'd0}, 1'b0, NO_WORD},
        '{ROW_CMD, '0, '0, {OP_NEXT, 4'd0, 4'd0}, 1'b1, {4'd15, 4'd0, 1'b1, 1'b1}},
        '{ROW_REG, REG_MAX_LENGTH, 5'd24, '0, 1'b0, NO_WORD},
        '{ROW_CMD, '0, '0, {OP_NEXT, 4'd0, 4'd0}, 1'b0, NO_WORD},
        '{ROW_CMD, '0, '0, {OP_SET_EDGE, 4'd15, 4'd15}, 1'b0, NO_WORD}
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [4:0] cfg_data = '0;
    logic       cmd_valid = 1'b0;
    logic       cmd_stall;
    cmd_item_t  cmd = '0;
    logic       res_valid;
    logic       res_stall = 1'b0;
    res_item_t  res;

    bounded_simple_path_enumerator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Predictor state: adjacency matrix, walk stack and register copies.
    logic [NV-1:0] adj_row [NV];
    logic [3:0]    path_v [NE+1];
    logic [4:0]    cur_at [NE+1];
    logic [NV-1:0] seen;
    int            depth;
    walk_state_t   walk;
    logic [4:0]    vcount_reg;
    logic [3:0]    start_reg;
    logic [3:0]    minlen_reg;
    logic [3:0]    maxlen_reg;

    res_item_t path_words [$];
    res_item_t pending_words [$];

    int  err_count = 0;
    int  n_cmds = 0;
    int  n_requests = 0;
    int  n_paths = 0;
    int  n_exhausted = 0;
    int  n_words = 0;
    int  n_settings = 0;
    bit  tx_idle_on = 1'b1;
    bit  rx_idle_on = 1'b1;
    int  rx_wait = 0;

    function automatic int eff_vcount();
        return (vcount_reg > NV) ? NV : int'(vcount_reg);
    endfunction

    function automatic int eff_maxlen();
        return (maxlen_reg > NE) ? NE : int'(maxlen_reg);
    endfunction

    // Depth-first step to the next arrival, one cursor per depth; 0 when the walk is over.
    function automatic bit walk_next_arrival();
        int            nv;
        int            d;
        int            i;
        logic [NV-1:0] row;
        bit            moved;
        bit            over;
        nv = eff_vcount();
        moved = 1'b0;
        over = 1'b0;
        while (!moved && !over)
        begin
            d = depth;
            if (d < eff_maxlen())
            begin
                row = adj_row[path_v[d]];
                i = cur_at[d];
                while (i < nv && !moved)
                begin
                    if (row[i] && !seen[i])
                    begin
                        cur_at[d] = 5'(i + 1);
                        path_v[d + 1] = 4'(i);
                        cur_at[d + 1] = '0;
                        seen[i] = 1'b1;
                        depth = d + 1;
                        moved = 1'b1;
                    end
                    i++;
                end
                if (!moved)
                    cur_at[d] = 5'(nv);
            end
            if (!moved)
            begin
                if (d == 0)
                    over = 1'b1;
                else
                begin
                    seen[path_v[d]] = 1'b0;
                    depth = d - 1;
                end
            end
        end
        return moved;
    endfunction

    function automatic bit in_window();
        return depth >= int'(minlen_reg) && depth <= eff_maxlen();
    endfunction

    // Updates the predictor for one accepted command and leaves its result words in path_words.
    function automatic void predict_words(input cmd_item_t w);
        bit        ok;
        int        k;
        res_item_t rw;
        path_words.delete();
        case (w.opcode)
            OP_SET_EDGE: adj_row[w.from_vertex][w.to_vertex] = 1'b1;
            OP_CLR_EDGE: adj_row[w.from_vertex][w.to_vertex] = 1'b0;
            OP_RESTART:
            begin
                walk = WALK_IDLE;
                seen = '0;
                depth = 0;
            end
            default:
            begin
                ok = 1'b0;
                if (walk == WALK_IDLE)
                begin
                    if (int'(start_reg) < eff_vcount() && int'(minlen_reg) <= eff_maxlen())
                    begin
                        depth = 0;
                        path_v[0] = start_reg;
                        cur_at[0] = '0;
                        seen = '0;
                        seen[start_reg] = 1'b1;
                        walk = WALK_ON;
                        ok = 1'b1;
                    end
                    else
                        walk = WALK_DONE;
                end
                else if (walk == WALK_ON)
                begin
                    ok = walk_next_arrival();
                    if (!ok)
                        walk = WALK_DONE;
                end
                while (ok && !in_window())
                begin
                    ok = walk_next_arrival();
                    if (!ok)
                        walk = WALK_DONE;
                end
                if (!ok)
                    path_words = {path_words, EXHAUSTED_WORD};
                else
                begin
                    for (k = 0; k <= depth; k++)
                    begin
                        rw = {path_v[k], k[3:0], 1'b1, k == depth};
                        path_words = {path_words, rw};
                    end
                end
            end
        endcase
    endfunction

    task automatic take_word(input res_item_t got);
        res_item_t want;
        n_words++;
        if (pending_words.size() == 0)
        begin
            err_count++;
            if (err_count <= MAX_REPORTS)
                $display("%0t: word with nothing expected: vertex=%0d position=%0d found=%0b last=%0b",
                         $time, got.vertex, got.position, got.found, got.last);
        end
        else
        begin
            want = pending_words.pop_front();
            if (got.vertex !== want.vertex || got.position !== want.position ||
                got.found !== want.found || got.last !== want.last)
            begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("%0t: word mismatch: expected v=%0d p=%0d f=%0b l=%0b, got v=%0d p=%0d f=%0b l=%0b",
                             $time, want.vertex, want.position, want.found, want.last,
                             got.vertex, got.position, got.found, got.last);
            end
        end
    endtask

    // Result side: random stall after each word and now and then while no word is taken.
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            take_word(res);
            rx_wait = rx_idle_on ? $urandom_range(0, 11) : 0;
        end
        else if (rx_wait > 0)
            rx_wait--;
        else if (rx_idle_on && $urandom_range(0, 15) == 0)
            rx_wait = $urandom_range(1, 11);
        res_stall <= (rx_wait != 0);
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (cmd_valid && !cmd_stall) || (res_valid && !res_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    task automatic send_word(input cmd_item_t w, input logic typed, input res_item_t want);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 11) : 0;
        if (gap != 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd <= w;
        do
            @(posedge clk);
        while (cmd_stall);
        predict_words(w);
        n_cmds++;
        if (w.opcode == OP_NEXT)
        begin
            n_requests++;
            if (path_words[0].found)
                n_paths++;
            else
                n_exhausted++;
        end
        if (typed)
            pending_words = {pending_words, want};
        else
            pending_words = {pending_words, path_words};
    endtask

    // Holds the command side until every expected word is in and the block has settled.
    task automatic quiesce();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // The caller lowers cfg_we after the last write of a group.
    task automatic put_reg(input logic [1:0] idx, input logic [4:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            REG_VERTEX_COUNT: vcount_reg = data;
            REG_START_VERTEX: start_reg = data[3:0];
            REG_MIN_LENGTH:   minlen_reg = data[3:0];
            default:          maxlen_reg = data[3:0];
        endcase
    endtask

    function automatic cmd_item_t random_word(input bit big);
        cmd_item_t w;
        int        r;
        int        span;
        span = (eff_vcount() == 0) ? NV : eff_vcount();
        r = $urandom_range(0, 99);
        w.from_vertex = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                    : 4'($urandom_range(0, span - 1));
        w.to_vertex = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                  : 4'($urandom_range(0, span - 1));
        if (r < (big ? 12 : 30))
            w.opcode = OP_SET_EDGE;
        else if (r < 45)
            w.opcode = OP_CLR_EDGE;
        else if (r < 53)
            w.opcode = OP_RESTART;
        else
            w.opcode = OP_NEXT;
        return w;
    endfunction

    initial
    begin
        int            i;
        int            j;
        int            ph;
        int            span;
        bit            big;
        logic [4:0]    vc;
        logic [3:0]    sv;
        logic [3:0]    mn;
        logic [3:0]    mx;
        logic [NV-1:0] used;
        logic [3:0]    cur;
        logic [3:0]    nxt;

        for (i = 0; i < NV; i++)
            adj_row[i] = '0;
        for (i = 0; i <= NE; i++)
        begin
            path_v[i] = '0;
            cur_at[i] = '0;
        end
        seen = '0;
        depth = 0;
        walk = WALK_IDLE;
        vcount_reg = VERTEX_COUNT_RST;
        start_reg = START_VERTEX_RST;
        minlen_reg = MIN_LENGTH_RST;
        maxlen_reg = MAX_LENGTH_RST;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < N_DIR; i++)
        begin
            if (dir_rows[i].kind == ROW_REG)
            begin
                if (i == 0 || dir_rows[i - 1].kind != ROW_REG)
                begin
                    quiesce();
                    n_settings++;
                end
                put_reg(dir_rows[i].idx, dir_rows[i].data);
                if (i + 1 == N_DIR || dir_rows[i + 1].kind != ROW_REG)
                    cfg_we <= 1'b0;
            end
            else
                send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want);
        end

        for (ph = 0; ph < N_PHASES; ph++)
        begin
            big = (ph == 5 || ph == 7);
            // Large graphs start from an empty matrix so that the walks stay short.
            if (big)
                for (i = 0; i < NV; i++)
                    for (j = 0; j < NV; j++)
                        if (adj_row[i][j])
                            send_word({OP_CLR_EDGE, 4'(i), 4'(j)}, 1'b0, NO_WORD);

            if (ph == 7)
                vc = 5'(NV + $urandom_range(1, 15));
            else if (ph == 5)
                vc = 5'(NV);
            else if (ph == 2)
                vc = 5'd0;
            else
                vc = 5'($urandom_range(1, 6));
            span = (vc > NV) ? NV : int'(vc);
            if (span == 0 || $urandom_range(0, 4) == 0)
                sv = 4'($urandom_range(0, 15));
            else
                sv = 4'($urandom_range(0, span - 1));
            case (ph)
                1:
                begin
                    mn = 4'($urandom_range(2, 4));
                    mx = 4'($urandom_range(8, 15));
                end
                3:
                begin
                    mn = 4'd0;
                    mx = 4'd0;
                end
                4:
                begin
                    mn = 4'($urandom_range(9, 15));
                    mx = 4'($urandom_range(0, 15));
                end
                5:
                begin
                    mn = 4'($urandom_range(0, 3));
                    mx = 4'd8;
                end
                6:
                begin
                    mn = 4'($urandom_range(1, 5));
                    mx = mn;
                end
                7:
                begin
                    mn = 4'($urandom_range(1, 3));
                    mx = 4'($urandom_range(4, 15));
                end
                default:
                begin
                    mn = 4'($urandom_range(0, 2));
                    mx = 4'($urandom_range(2, 8));
                end
            endcase

            quiesce();
            put_reg(REG_VERTEX_COUNT, vc);
            put_reg(REG_START_VERTEX, {1'($urandom_range(0, 1)), sv});
            put_reg(REG_MIN_LENGTH, {1'($urandom_range(0, 1)), mn});
            put_reg(REG_MAX_LENGTH, {1'($urandom_range(0, 1)), mx});
            cfg_we <= 1'b0;
            n_settings++;
            tx_idle_on = (ph != 3) && ($urandom_range(0, 4) != 0);
            rx_idle_on = (ph != 3) && ($urandom_range(0, 4) != 0);

            // A chain of full length from the start vertex so the walk reaches the depth limit.
            if (big)
            begin
                used = '0;
                used[sv] = 1'b1;
                cur = sv;
                for (j = 0; j < NE; j++)
                begin
                    do
                        nxt = 4'($urandom_range(0, 15));
                    while (used[nxt]);
                    used[nxt] = 1'b1;
                    send_word({OP_SET_EDGE, cur, nxt}, 1'b0, NO_WORD);
                    cur = nxt;
                end
                send_word({OP_RESTART, 4'd0, 4'd0}, 1'b0, NO_WORD);
            end

            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                if ($urandom_range(0, 24) == 0)
                    quiesce();
                send_word(random_word(big), 1'b0, NO_WORD);
            end
        end

        quiesce();
        repeat (TAIL_CYCLES) @(posedge clk);
        err_count += pending_words.size();

        $display("Sent %0d commands over %0d register settings; %0d next-path requests gave",
                 n_cmds, n_settings, n_requests);
        $display("%0d paths and %0d exhausted answers, %0d result words checked.",
                 n_paths, n_exhausted, n_words);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- bounded_simple_path_enumerator_unit.f -----
rtl/bspe_pkg.sv
rtl/bspe_datapath.sv
rtl/bspe_ctrl.sv
rtl/bounded_simple_path_enumerator_unit.sv
bench/tb_top.sv
